FILE: src/bezier_segment_tessellator_macros.svh
// Assertion macros for the bezier segment tessellator
`ifndef BEZIER_SEGMENT_TESSELLATOR_MACROS_SVH
`define BEZIER_SEGMENT_TESSELLATOR_MACROS_SVH

// Antecedent implies consequent in the same cycle
`define BST_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Condition never holds
`define BST_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

FILE: src/bst_pkg.sv
// Types and helpers shared by the bezier segment tessellator
`timescale 1ns / 1ps
`default_nettype none
package bst_pkg;

   localparam int QFRAC = 16;
   localparam int PIPE_DEPTH = 9;

   localparam logic [1:0] KIND_PARABOLA = 2'd0;
   localparam logic [1:0] KIND_QUAD     = 2'd1;
   localparam logic [1:0] KIND_CUBIC    = 2'd2;
   localparam logic [1:0] KIND_NONE     = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   // one pipeline stage: three mix lanes plus the values they feed
   typedef struct packed {
      logic             valid;
      logic [1:0]       kind;
      logic [31:0]      t;
      logic             seg_end;
      logic             last;
      logic [3:0][31:0] v;
      logic [2:0][32:0] dif;
      logic [2:0][64:0] prd;
   } pipe_type;

   // clamp a wide signed value to the signed 32-bit range
   function automatic logic [31:0] sat32(input logic signed [49:0] x);
      logic [31:0] r;
      if (x > 50'sd2147483647)       r = 32'h7FFF_FFFF;
      else if (x < -50'sd2147483648) r = 32'h8000_0000;
      else                           r = x[31:0];
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: src/bezier_segment_tessellator.sv
// Bezier segment tessellator: dt divider, vertex sequencer, de Casteljau pipeline
//
//  channel | dir | handshake             | word
//  req     | in  | req_valid/req_ready   | curve kind, control values, interval, count
//  rsp     | out | rsp_valid/rsp_ready   | vertex x, y, segment_end, last_vertex
//
// A request first runs the serial divider (one quotient bit per cycle); then, while
// rsp is not stalled, one vertex enters the nine stage mix pipeline per cycle:
// 2*count vertices per request.
// Reset clears the sequencer state and the pipeline valid bits only.
// A stalled rsp freezes the whole pipeline and the vertex issue (the divider keeps running); nothing is lost.
`timescale 1ns / 1ps
`default_nettype none
`include "bezier_segment_tessellator_macros.svh"
module bezier_segment_tessellator
   import bst_pkg::*;
#(
   parameter int MAX_SEGMENTS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_type,
   input  wire logic [31:0] req_point_a,
   input  wire logic [31:0] req_point_b,
   input  wire logic [31:0] req_point_c,
   input  wire logic [31:0] req_point_d,
   input  wire logic [31:0] req_t_start,
   input  wire logic [31:0] req_t_end,
   input  wire logic [5:0]  req_segment_count,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_vertex_x,
   output logic [31:0]      rsp_vertex_y,
   output logic             rsp_segment_end,
   output logic             rsp_last_vertex
);

   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam int DIV_STEPS = 33;

   state_type        state_ff, state_in;
   logic [1:0]       kind_ff, kind_in;
   logic [3:0][31:0] pts_ff, pts_in;
   logic [31:0]      t_ff, t_in;
   logic [32:0]      dt_ff, dt_in;
   logic [32:0]      mag_ff, mag_in;
   logic [6:0]       rem_ff, rem_in;
   logic [5:0]       step_ff, step_in;
   logic             neg_ff, neg_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic             half_ff, half_in;

   pipe_type pipe_ff [PIPE_DEPTH];
   pipe_type nxt     [PIPE_DEPTH];
   pipe_type entry;

   logic          en;
   logic          accept;
   logic [5:0]    cnt_clamp;
   logic [32:0]   diff;
   logic [6:0]    rem_sh;
   logic [33:0]   t_sum;
   logic          last_seg;

   assign en        = !pipe_ff[PIPE_DEPTH-1].valid || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign cnt_clamp = (req_segment_count > 6'(MAX_SEGMENTS)) ? 6'(MAX_SEGMENTS)
                                                             : req_segment_count;
   assign diff      = {req_t_end[31], req_t_end} - {req_t_start[31], req_t_start};
   assign rem_sh    = {rem_ff[5:0], mag_ff[32]};
   assign t_sum     = {{2{t_ff[31]}}, t_ff} + {dt_ff[32], dt_ff};
   assign last_seg  = (idx_ff == cnt_ff - CW'(1));

   // request sequencer: divide, then issue two vertices per segment
   always_comb begin
      state_in = state_ff;
      kind_in  = kind_ff;
      pts_in   = pts_ff;
      t_in     = t_ff;
      dt_in    = dt_ff;
      mag_in   = mag_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      half_in  = half_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_type != KIND_NONE && cnt_clamp != 6'd0) begin
               state_in = ST_DIV;
               kind_in  = req_type;
               pts_in   = {req_point_d, req_point_c, req_point_b, req_point_a};
               t_in     = req_t_start;
               neg_in   = diff[32];
               mag_in   = diff[32] ? (33'd0 - diff) : diff;
               rem_in   = '0;
               step_in  = '0;
               cnt_in   = CW'(cnt_clamp);
               idx_in   = '0;
               half_in  = 1'b0;
            end
         end
         ST_DIV: begin
            // restoring divide, one quotient bit per cycle
            if (step_ff == 6'(DIV_STEPS)) begin
               dt_in    = neg_ff ? (33'd0 - mag_ff) : mag_ff;
               state_in = ST_EMIT;
            end else begin
               if (rem_sh >= 7'(cnt_ff)) begin
                  rem_in = rem_sh - 7'(cnt_ff);
                  mag_in = {mag_ff[31:0], 1'b1};
               end else begin
                  rem_in = rem_sh;
                  mag_in = {mag_ff[31:0], 1'b0};
               end
               step_in = step_ff + 6'd1;
            end
         end
         ST_EMIT: begin
            if (en) begin
               if (!half_ff) begin
                  half_in = 1'b1;
                  t_in    = sat32(50'(signed'(t_sum)));
               end else begin
                  half_in = 1'b0;
                  idx_in  = idx_ff + CW'(1);
                  if (last_seg) state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      kind_ff  <= kind_in;
      pts_ff   <= pts_in;
      t_ff     <= t_in;
      dt_ff    <= dt_in;
      mag_ff   <= mag_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      neg_ff   <= neg_in;
      cnt_ff   <= cnt_in;
      idx_ff   <= idx_in;
      half_ff  <= half_in;
   end

   // word entering the pipeline
   always_comb begin
      entry         = '0;
      entry.valid   = (state_ff == ST_EMIT);
      entry.kind    = kind_ff;
      entry.t       = t_ff;
      entry.seg_end = half_ff;
      entry.last    = half_ff && last_seg;
      entry.v       = pts_ff;
   end

   // three mix levels, each split into subtract, multiply, add-and-clamp
   always_comb begin
      logic [2:0][31:0] p;
      logic [2:0][31:0] q;
      for (int s = 0; s < PIPE_DEPTH; s++) begin
         nxt[s] = (s == 0) ? entry : pipe_ff[s-1];
         p = '0;
         q = '0;
         if (s % 3 == 0) begin
            // pick lane operands for this level
            if (s == 0) begin
               p[0] = (nxt[s].kind == KIND_PARABOLA) ? 32'd0 : nxt[s].v[0];
               q[0] = (nxt[s].kind == KIND_PARABOLA) ? nxt[s].t : nxt[s].v[1];
               p[1] = nxt[s].v[1];
               q[1] = nxt[s].v[2];
               p[2] = nxt[s].v[2];
               q[2] = nxt[s].v[3];
            end else if (s == 3) begin
               p[0] = nxt[s].v[0];
               q[0] = (nxt[s].kind == KIND_PARABOLA) ? nxt[s].v[0] : nxt[s].v[1];
               p[1] = nxt[s].v[1];
               q[1] = nxt[s].v[2];
            end else begin
               p[0] = nxt[s].v[0];
               q[0] = (nxt[s].kind == KIND_CUBIC) ? nxt[s].v[1] : nxt[s].v[0];
            end
            for (int l = 0; l < 3; l++) begin
               nxt[s].v[l]   = p[l];
               nxt[s].dif[l] = {q[l][31], q[l]} - {p[l][31], p[l]};
            end
         end else if (s % 3 == 1) begin
            for (int l = 0; l < 3; l++)
               nxt[s].prd[l] = 65'($signed(nxt[s].dif[l]) * $signed(nxt[s].t));
         end else begin
            for (int l = 0; l < 3; l++)
               nxt[s].v[l] = sat32($signed({{18{nxt[s].v[l][31]}}, nxt[s].v[l]})
                                 + $signed({nxt[s].prd[l][64], nxt[s].prd[l][64:QFRAC]}));
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < PIPE_DEPTH; s++) begin
         if (reset) pipe_ff[s].valid <= 1'b0;
         else if (en) pipe_ff[s] <= nxt[s];
      end
   end

   assign rsp_valid       = pipe_ff[PIPE_DEPTH-1].valid;
   assign rsp_vertex_x    = pipe_ff[PIPE_DEPTH-1].t;
   assign rsp_vertex_y    = pipe_ff[PIPE_DEPTH-1].v[0];
   assign rsp_segment_end = pipe_ff[PIPE_DEPTH-1].seg_end;
   assign rsp_last_vertex = pipe_ff[PIPE_DEPTH-1].last;

   // checks
   `BST_ASSERT_IMPL(a_idle_no_issue, clock, reset, req_ready, !entry.valid, "issue while idle")
   `BST_ASSERT_IMPL(a_last_is_end, clock, reset, rsp_valid && rsp_last_vertex, rsp_segment_end, "last vertex not a segment end")
   `BST_ASSERT_NEVER(a_div_bound, clock, reset, state_ff == ST_DIV && step_ff > 6'(DIV_STEPS), "divider overran")

endmodule
`default_nettype wire
